>>> hdl/dspi_pkg.sv
// shared types and constants for the display serial master
package dspi_pkg;

  localparam int BITS_PER_WORD = 8;
  localparam int PHASES        = 2 * BITS_PER_WORD;
  localparam int PH_W          = $clog2(PHASES);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_CMD     = 3'd0,
    OP_DATA    = 3'd1,
    OP_READ    = 3'd2,
    OP_DESEL   = 3'd3,
    OP_SET_RST = 3'd4,
    OP_SET_PWR = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    KIND_SHIFT_OUT,
    KIND_SHIFT_IN,
    KIND_DESELECT,
    KIND_SET_RESET,
    KIND_SET_POWER
  } kind_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_SHIFT
  } seq_e;

  typedef struct packed {
    kind_e                    kind;
    logic                     dc;
    logic [BITS_PER_WORD-1:0] byte_value;
    logic [BITS_PER_WORD-1:0] incoming_bits;
    logic                     level;
  } cmd_t;

  typedef struct packed {
    logic                     cs_n;
    logic                     dc;
    logic                     sclk;
    logic                     mosi;
    logic                     mosi_drive;
    logic                     rst_pin;
    logic                     pwr_pin;
    logic [BITS_PER_WORD-1:0] read_data;
    logic                     last;
  } res_t;

endpackage

>>> hdl/dspi_front.sv
// input stage: accepts beats, decodes the op and drops undefined codes
module dspi_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         op_i,
  input  logic [dspi_pkg::BITS_PER_WORD-1:0] byte_value_i,
  input  logic [dspi_pkg::BITS_PER_WORD-1:0] incoming_bits_i,
  input  logic                               level_i,
  output logic                               push_o,
  output dspi_pkg::cmd_t                     push_data_o,
  input  logic                               q_full_i
);

  logic           valid_q, valid_d;
  dspi_pkg::cmd_t cmd_q, cmd_d;
  logic           accept;
  logic           op_ok;

  assign push_o      = valid_q && !q_full_i;
  assign in_stall_o  = valid_q && q_full_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_data_o = cmd_q;

  always_comb begin
    op_ok              = 1'b1;
    cmd_d.kind         = dspi_pkg::KIND_SHIFT_OUT;
    cmd_d.dc           = 1'b0;
    cmd_d.byte_value   = byte_value_i;
    cmd_d.incoming_bits = incoming_bits_i;
    cmd_d.level        = level_i;
    unique case (op_i)
      dspi_pkg::OP_CMD: begin
        cmd_d.kind = dspi_pkg::KIND_SHIFT_OUT;
        cmd_d.dc   = 1'b0;
      end
      dspi_pkg::OP_DATA: begin
        cmd_d.kind = dspi_pkg::KIND_SHIFT_OUT;
        cmd_d.dc   = 1'b1;
      end
      dspi_pkg::OP_READ: begin
        cmd_d.kind = dspi_pkg::KIND_SHIFT_IN;
        cmd_d.dc   = 1'b1;
      end
      dspi_pkg::OP_DESEL:   cmd_d.kind = dspi_pkg::KIND_DESELECT;
      dspi_pkg::OP_SET_RST: cmd_d.kind = dspi_pkg::KIND_SET_RESET;
      dspi_pkg::OP_SET_PWR: cmd_d.kind = dspi_pkg::KIND_SET_POWER;
      default:              op_ok      = 1'b0;
    endcase
  end

  assign valid_d = (accept && op_ok) || (valid_q && !push_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op_ok) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

>>> hdl/dspi_queue.sv
// short command queue between decode and the pin sequencer
module dspi_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dspi_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dspi_pkg::cmd_t head_o
);

  dspi_pkg::cmd_t                   mem_q [dspi_pkg::QUEUE_DEPTH];
  logic [dspi_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [dspi_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [dspi_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                             do_push, do_pop;

  assign full_o  = (count_q == dspi_pkg::QCNT_W'(dspi_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == dspi_pkg::QPTR_W'(dspi_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + dspi_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == dspi_pkg::QPTR_W'(dspi_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + dspi_pkg::QPTR_W'(1);
    end
    priority if (do_push && !do_pop) begin
      count_d = count_q + dspi_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - dspi_pkg::QCNT_W'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dspi_pkg::QCNT_W'(dspi_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");

endmodule

>>> hdl/dspi_back.sv
// pin sequencer: held pin levels, half-bit phase generation and result register
module dspi_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  dspi_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dspi_pkg::res_t res_o
);

  localparam int MSB = dspi_pkg::BITS_PER_WORD - 1;

  dspi_pkg::seq_e state_q, state_d;

  logic cs_q, cs_d;
  logic dc_q, dc_d;
  logic clk_q, clk_d;
  logic dat_q, dat_d;
  logic rst_q, rst_d;
  logic pwr_q, pwr_d;
  logic rd_q, rd_d;
  logic [dspi_pkg::PH_W-1:0] phase_q, phase_d;
  logic [MSB:0] sh_q, sh_d;
  logic [MSB:0] inc_q, inc_d;
  logic [MSB:0] acc_q, acc_d;

  logic                      out_valid_q, out_valid_d;
  dspi_pkg::res_t            res_q, res_d;

  logic                      advance;
  logic                      emit;
  logic                      shift_step;
  logic                      phase_last;
  logic                      cur_rd;
  logic [dspi_pkg::PH_W-1:0] cur_phase;
  logic [MSB:0]              cur_sh, cur_inc, cur_acc;
  logic                      head_is_byte;

  assign advance      = !out_valid_q || !out_stall_i;
  assign head_is_byte = (head_i.kind == dspi_pkg::KIND_SHIFT_OUT) ||
                        (head_i.kind == dspi_pkg::KIND_SHIFT_IN);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dspi_pkg::SEQ_IDLE: begin
        if (q_valid_i && advance && head_is_byte) begin
          state_d = dspi_pkg::SEQ_SHIFT;
        end
      end
      dspi_pkg::SEQ_SHIFT: begin
        if (advance && phase_q == dspi_pkg::PH_W'(dspi_pkg::PHASES - 1)) begin
          state_d = dspi_pkg::SEQ_IDLE;
        end
      end
      default: state_d = dspi_pkg::SEQ_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cs_d       = cs_q;
    dc_d       = dc_q;
    clk_d      = clk_q;
    dat_d      = dat_q;
    rst_d      = rst_q;
    pwr_d      = pwr_q;
    rd_d       = rd_q;
    phase_d    = phase_q;
    sh_d       = sh_q;
    inc_d      = inc_q;
    acc_d      = acc_q;
    emit       = 1'b0;
    pop_o      = 1'b0;
    shift_step = 1'b0;
    cur_phase  = phase_q;
    cur_sh     = sh_q;
    cur_inc    = inc_q;
    cur_acc    = acc_q;
    cur_rd     = rd_q;

    unique case (state_q)
      dspi_pkg::SEQ_IDLE: begin
        cur_phase = '0;
        cur_sh    = head_i.byte_value;
        cur_inc   = head_i.incoming_bits;
        cur_acc   = '0;
        cur_rd    = (head_i.kind == dspi_pkg::KIND_SHIFT_IN);
        if (q_valid_i && advance) begin
          pop_o = 1'b1;
          emit  = 1'b1;
          unique case (head_i.kind)
            dspi_pkg::KIND_SHIFT_OUT, dspi_pkg::KIND_SHIFT_IN: begin
              cs_d       = 1'b0;
              dc_d       = head_i.dc;
              rd_d       = cur_rd;
              shift_step = 1'b1;
            end
            dspi_pkg::KIND_DESELECT:  cs_d  = 1'b1;
            dspi_pkg::KIND_SET_RESET: rst_d = head_i.level;
            dspi_pkg::KIND_SET_POWER: pwr_d = head_i.level;
            default: ;
          endcase
        end
      end
      dspi_pkg::SEQ_SHIFT: begin
        if (advance) begin
          emit       = 1'b1;
          shift_step = 1'b1;
        end
      end
      default: ;
    endcase

    phase_last = (cur_phase == dspi_pkg::PH_W'(dspi_pkg::PHASES - 1));

    if (shift_step) begin
      phase_d = cur_phase + dspi_pkg::PH_W'(1);
      if (!cur_phase[0]) begin
        clk_d = 1'b0;
        if (!cur_rd) begin
          dat_d = cur_sh[MSB];
        end
        sh_d  = {cur_sh[MSB-1:0], 1'b0};
        inc_d = cur_inc;
        acc_d = cur_acc;
      end else begin
        clk_d = 1'b1;
        if (cur_rd) begin
          acc_d = {cur_acc[MSB-1:0], cur_inc[MSB]};
        end else begin
          acc_d = cur_acc;
        end
        inc_d = {cur_inc[MSB-1:0], 1'b0};
        sh_d  = cur_sh;
      end
    end

    res_d.cs_n       = cs_d;
    res_d.dc         = dc_d;
    res_d.sclk       = clk_d;
    res_d.mosi_drive = !(shift_step && cur_rd);
    res_d.mosi       = res_d.mosi_drive ? dat_d : 1'b0;
    res_d.rst_pin    = rst_d;
    res_d.pwr_pin    = pwr_d;
    res_d.read_data  = (shift_step && cur_rd && phase_last) ? acc_d : '0;
    res_d.last       = !shift_step || phase_last;
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dspi_pkg::SEQ_IDLE;
      cs_q        <= 1'b1;
      dc_q        <= 1'b0;
      clk_q       <= 1'b0;
      dat_q       <= 1'b0;
      rst_q       <= 1'b0;
      pwr_q       <= 1'b0;
      rd_q        <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cs_q        <= cs_d;
      dc_q        <= dc_d;
      clk_q       <= clk_d;
      dat_q       <= dat_d;
      rst_q       <= rst_d;
      pwr_q       <= pwr_d;
      rd_q        <= rd_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    inc_q <= inc_d;
    acc_q <= acc_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

  a_select_while_shifting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dspi_pkg::SEQ_SHIFT |-> !cs_q)
    else $error("chip select high during a byte");

  a_read_data_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.read_data != '0) |-> res_q.last && !res_q.mosi_drive)
    else $error("read data outside the final read phase");

  a_shift_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dspi_pkg::SEQ_SHIFT && advance &&
    phase_q == dspi_pkg::PH_W'(dspi_pkg::PHASES - 1) |=> state_q == dspi_pkg::SEQ_IDLE)
    else $error("sequencer did not return to idle after the last phase");

endmodule

>>> hdl/display_spi_master_with_dc.sv
// top level of the display serial master with data/command line
// a byte item gives 16 result beats, one per cycle unless the output stalls, the first
//   in the cycle after it leaves the two-entry queue; pin items give one beat
// the phase sequencer takes no new item until a byte item has run all of its phases
// an input beat passes the front register, a queue entry and the result register
// reset: held cs_n level high, all other held pin levels low, queue and result register empty
module display_spi_master_with_dc (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         op_i,
  input  logic [dspi_pkg::BITS_PER_WORD-1:0] byte_value_i,
  input  logic [dspi_pkg::BITS_PER_WORD-1:0] incoming_bits_i,
  input  logic                               level_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               cs_n_o,
  output logic                               dc_o,
  output logic                               sclk_o,
  output logic                               mosi_o,
  output logic                               mosi_drive_o,
  output logic                               rst_pin_o,
  output logic                               pwr_pin_o,
  output logic [dspi_pkg::BITS_PER_WORD-1:0] read_data_o,
  output logic                               last_o
);

  logic           push;
  dspi_pkg::cmd_t push_data;
  logic           q_full;
  logic           q_valid;
  logic           pop;
  dspi_pkg::cmd_t head;
  dspi_pkg::res_t res;

  dspi_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .byte_value_i    (byte_value_i),
    .incoming_bits_i (incoming_bits_i),
    .level_i         (level_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .q_full_i        (q_full)
  );

  dspi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  dspi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign cs_n_o       = res.cs_n;
  assign dc_o         = res.dc;
  assign sclk_o       = res.sclk;
  assign mosi_o       = res.mosi;
  assign mosi_drive_o = res.mosi_drive;
  assign rst_pin_o    = res.rst_pin;
  assign pwr_pin_o    = res.pwr_pin;
  assign read_data_o  = res.read_data;
  assign last_o       = res.last;

endmodule
